// ===== rtl/core/thfe_pkg.sv =====
// TLS hello field extractor: shared types and constants.
// Result beat layout, event kind codes and protocol constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package thfe_pkg;

    localparam logic [7:0]  HANDSHAKE_CT   = 8'd22;
    localparam logic [15:0] HELLO_FIXED    = 16'd34;
    localparam logic [15:0] SNI_LIST_BYTES = 16'd5;
    localparam logic [15:0] HT_CLIENT      = 16'd1;
    localparam logic [15:0] HT_SERVER      = 16'd2;

    localparam logic [1:0] EV_OFFERED   = 2'd0;
    localparam logic [1:0] EV_CHOSEN    = 2'd1;
    localparam logic [1:0] EV_NAME_BYTE = 2'd2;
    localparam logic [1:0] EV_NAME_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [14:0] number;
    } t_event;

endpackage

`default_nettype wire

// ===== rtl/core/thfe_if.sv =====
// TLS hello field extractor: valid/ready channels for payload and event beats.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface thfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       segment_start;
    logic       to_server;

    modport source (output valid, output payload_byte, output segment_start,
                    output to_server, input ready);
    modport sink   (input valid, input payload_byte, input segment_start,
                    input to_server, output ready);
endinterface

interface thfe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [15:0] event_value;
    logic [14:0] suite_number;

    modport source (output valid, output event_kind, output event_value,
                    output suite_number, input ready);
    modport sink   (input valid, input event_kind, input event_value,
                    input suite_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/thfe_parser.sv =====
// TLS hello field extractor: byte-wise record and handshake parser.
// Holds the parse state, advances once per accepted payload beat.
// Depends on thfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thfe_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_seg_start,
    input  wire logic           i_to_server,
    output logic                o_res_valid,
    output thfe_pkg::t_event    o_res
);
    import thfe_pkg::*;

    typedef enum logic [30:0] {
        PH_REC_TYPE  = 31'h00000001,
        PH_REC_V1    = 31'h00000002,
        PH_REC_V2    = 31'h00000004,
        PH_REC_L1    = 31'h00000008,
        PH_REC_L2    = 31'h00000010,
        PH_HS_TYPE   = 31'h00000020,
        PH_HS_L1     = 31'h00000040,
        PH_HS_L2     = 31'h00000080,
        PH_HS_L3     = 31'h00000100,
        PH_HS_SKIP   = 31'h00000200,
        PH_FIXED     = 31'h00000400,
        PH_SID_LEN   = 31'h00000800,
        PH_SID_SKIP  = 31'h00001000,
        PH_CS_L1     = 31'h00002000,
        PH_CS_L2     = 31'h00004000,
        PH_CS_HI     = 31'h00008000,
        PH_CS_LO     = 31'h00010000,
        PH_COMP_LEN  = 31'h00020000,
        PH_COMP_SKIP = 31'h00040000,
        PH_SRV_C1    = 31'h00080000,
        PH_SRV_C2    = 31'h00100000,
        PH_SRV_COMP  = 31'h00200000,
        PH_EXT_L1    = 31'h00400000,
        PH_EXT_L2    = 31'h00800000,
        PH_EXT_T1    = 31'h01000000,
        PH_EXT_T2    = 31'h02000000,
        PH_EXT_N1    = 31'h04000000,
        PH_EXT_N2    = 31'h08000000,
        PH_EXT_SKIP  = 31'h10000000,
        PH_SNI       = 31'h20000000,
        PH_IGNORE    = 31'h40000000
    } t_phase;

    t_phase      r_phase, n_phase, ph;
    logic        r_dir, n_dir;
    logic [15:0] r_rec, n_rec;
    logic [23:0] r_hs, n_hs;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_ext, n_ext;
    logic [15:0] r_ext_type, n_ext_type;
    logic [15:0] r_ext_len, n_ext_len;
    logic [7:0]  r_high, n_high;
    logic [14:0] r_suite, n_suite;
    logic        r_owed, n_owed;

    logic        in_record, in_body, in_ext;
    logic [15:0] word;
    logic        has, named;
    t_event      ev;

    always_comb begin
        ph         = i_seg_start ? PH_REC_TYPE : r_phase;
        n_dir      = i_seg_start ? i_to_server : r_dir;
        in_record  = |ph[29:5];
        in_body    = |ph[29:9];
        in_ext     = |ph[29:24];
        word       = {r_high, i_byte};
        n_phase    = ph;
        n_rec      = in_record ? r_rec - 16'd1 : r_rec;
        n_hs       = in_body ? r_hs - 24'd1 : r_hs;
        n_ext      = (in_ext && r_ext != 16'd0) ? r_ext - 16'd1 : r_ext;
        n_skip     = r_skip;
        n_ext_type = r_ext_type;
        n_ext_len  = r_ext_len;
        n_high     = r_high;
        n_suite    = r_suite;
        n_owed     = 1'b0;
        has        = 1'b0;
        named      = 1'b0;
        ev         = '0;

        case (ph)
            PH_REC_TYPE: n_phase = (i_byte == HANDSHAKE_CT) ? PH_REC_V1 : PH_IGNORE;
            PH_REC_V1:   n_phase = PH_REC_V2;
            PH_REC_V2:   n_phase = PH_REC_L1;
            PH_REC_L1: begin
                n_high  = i_byte;
                n_phase = PH_REC_L2;
            end
            PH_REC_L2: begin
                n_rec   = word;
                n_phase = (word != 16'd0) ? PH_HS_TYPE : PH_IGNORE;
            end
            PH_HS_TYPE: begin
                n_ext_type = {8'd0, i_byte};
                n_hs       = '0;
                n_phase    = PH_HS_L1;
            end
            PH_HS_L1: begin
                n_hs    = {r_hs[15:0], i_byte};
                n_phase = PH_HS_L2;
            end
            PH_HS_L2: begin
                n_hs    = {r_hs[15:0], i_byte};
                n_phase = PH_HS_L3;
            end
            PH_HS_L3: begin
                n_hs = {r_hs[15:0], i_byte};
                if (n_hs == 24'd0) begin
                    n_phase = PH_HS_TYPE;
                end else if (r_ext_type == (r_dir ? HT_CLIENT : HT_SERVER)) begin
                    n_skip  = HELLO_FIXED;
                    n_phase = PH_FIXED;
                end else begin
                    n_phase = PH_HS_SKIP;
                end
            end
            PH_HS_SKIP: n_phase = PH_HS_SKIP;
            PH_FIXED: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) n_phase = PH_SID_LEN;
            end
            PH_SID_LEN: begin
                n_skip = {8'd0, i_byte};
                if (i_byte != 8'd0) n_phase = PH_SID_SKIP;
                else n_phase = n_dir ? PH_CS_L1 : PH_SRV_C1;
            end
            PH_SID_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) n_phase = n_dir ? PH_CS_L1 : PH_SRV_C1;
            end
            PH_CS_L1: begin
                n_high  = i_byte;
                n_phase = PH_CS_L2;
            end
            PH_CS_L2: begin
                n_skip  = {word[15:1], 1'b0};
                n_suite = '0;
                n_phase = (word[15:1] != 15'd0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_CS_HI: begin
                n_high  = i_byte;
                n_skip  = r_skip - 16'd1;
                n_phase = PH_CS_LO;
            end
            PH_CS_LO: begin
                n_skip    = r_skip - 16'd1;
                n_suite   = r_suite + 15'd1;
                has       = 1'b1;
                ev.kind   = EV_OFFERED;
                ev.value  = word;
                ev.number = n_suite;
                n_phase   = (n_skip != 16'd0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
                n_skip  = {8'd0, i_byte};
                n_phase = (i_byte != 8'd0) ? PH_COMP_SKIP : PH_EXT_L1;
            end
            PH_COMP_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) n_phase = PH_EXT_L1;
            end
            PH_SRV_C1: begin
                n_high  = i_byte;
                n_phase = PH_SRV_C2;
            end
            PH_SRV_C2: begin
                has      = 1'b1;
                ev.kind  = EV_CHOSEN;
                ev.value = word;
                n_phase  = PH_SRV_COMP;
            end
            PH_SRV_COMP: n_phase = PH_EXT_L1;
            PH_EXT_L1: begin
                n_high  = i_byte;
                n_phase = PH_EXT_L2;
            end
            PH_EXT_L2: begin
                n_ext   = word;
                n_phase = (word != 16'd0) ? PH_EXT_T1 : PH_HS_SKIP;
            end
            PH_EXT_T1: begin
                n_high  = i_byte;
                n_phase = PH_EXT_T2;
            end
            PH_EXT_T2: begin
                n_ext_type = word;
                n_phase    = PH_EXT_N1;
            end
            PH_EXT_N1: begin
                n_high  = i_byte;
                n_phase = PH_EXT_N2;
            end
            PH_EXT_N2: begin
                n_ext_len = word;
                n_skip    = word;
                if (r_ext_type == 16'd0) begin
                    if (word == 16'd0) begin
                        has     = 1'b1;
                        ev.kind = EV_NAME_DONE;
                        n_phase = PH_HS_SKIP;
                    end else begin
                        n_phase = PH_SNI;
                    end
                end else if (word != 16'd0) begin
                    n_phase = PH_EXT_SKIP;
                end else begin
                    n_phase = (n_ext != 16'd0) ? PH_EXT_T1 : PH_HS_SKIP;
                end
            end
            PH_EXT_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) n_phase = (n_ext != 16'd0) ? PH_EXT_T1 : PH_HS_SKIP;
            end
            PH_SNI: begin
                if ((r_ext_len - r_skip) >= SNI_LIST_BYTES) begin
                    has      = 1'b1;
                    ev.kind  = EV_NAME_BYTE;
                    ev.value = {8'd0, i_byte};
                    named    = 1'b1;
                end
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    if (named) begin
                        n_owed = 1'b1;
                    end else begin
                        has     = 1'b1;
                        ev.kind = EV_NAME_DONE;
                    end
                    n_phase = PH_HS_SKIP;
                end
            end
            default: n_phase = PH_IGNORE;
        endcase

        if (in_body && n_hs == 24'd0) n_phase = PH_HS_TYPE;
        if (in_record && n_rec == 16'd0) n_phase = PH_IGNORE;

        if (r_owed) begin
            has = 1'b1;
            ev  = '0;
            ev.kind = EV_NAME_DONE;
        end
    end

    assign o_res_valid = i_step && has;
    assign o_res       = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_REC_TYPE;
            r_dir      <= 1'b0;
            r_rec      <= '0;
            r_hs       <= '0;
            r_skip     <= '0;
            r_ext      <= '0;
            r_ext_type <= '0;
            r_ext_len  <= '0;
            r_high     <= '0;
            r_suite    <= '0;
            r_owed     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_dir      <= n_dir;
            r_rec      <= n_rec;
            r_hs       <= n_hs;
            r_skip     <= n_skip;
            r_ext      <= n_ext;
            r_ext_type <= n_ext_type;
            r_ext_len  <= n_ext_len;
            r_high     <= n_high;
            r_suite    <= n_suite;
            r_owed     <= n_owed;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tls_hello_field_extractor.sv =====
// TLS hello field extractor: top level.
// Payload bytes in on i_in, cipher suite and server name events out on o_out.
// Payload channel (i_in): one TCP payload byte per beat, after the TCP options.
//   segment_start marks the first byte of a segment and restarts parsing at
//   the record header; to_server is sampled on that beat.
// Event channel (o_out): zero or one event per payload beat. Offered suites
//   carry a one-based suite_number, chosen suites and name bytes carry zero.
//   The name-done event after a final name byte rides on the next payload beat.
// An event is registered in the output register, or in the skid register while o_out stalls.
// Throughput: one payload beat per cycle while i_in.ready is high; the parser
//   state advances once per beat through a single registered pass.
// Stall: an output register and one skid register hold events; i_in.ready
//   drops only while both are full, and rises once o_out takes a beat.
// Reset (i_rst_n, synchronous, active low): parser waits for a record header
//   from the server side, all counters clear and both event registers empty.
// Depends on thfe_pkg, thfe_if and thfe_parser.
`timescale 1ns / 1ps
`default_nettype none

module tls_hello_field_extractor (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    thfe_in_if.sink     i_in,
    thfe_out_if.source  o_out
);
    import thfe_pkg::*;

    logic   step, pop;
    logic   res_valid;
    t_event res;
    logic   r_out_valid, r_skid_valid;
    t_event r_out, r_skid;

    assign i_in.ready = !r_skid_valid;
    assign step       = i_in.valid && !r_skid_valid;
    assign pop        = r_out_valid && o_out.ready;

    thfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (i_in.payload_byte),
        .i_seg_start (i_in.segment_start),
        .i_to_server (i_in.to_server),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) r_out <= r_skid;
        end else if (!r_out_valid || pop) begin
            if (res_valid) r_out <= res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out.kind;
    assign o_out.event_value  = r_out.value;
    assign o_out.suite_number = r_out.number;

endmodule

`default_nettype wire

// ===== rtl/core/thfe_checker.sv =====
// TLS hello field extractor: port-level checks, bound to the top level.
// Depends on thfe_pkg and tls_hello_field_extractor.
`timescale 1ns / 1ps
`default_nettype none

module thfe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_kind,
    input wire logic [15:0] i_value,
    input wire logic [14:0] i_number
);
    import thfe_pkg::*;

    // only offered suites are numbered, and they are numbered from one
    a_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_kind == EV_OFFERED) ? (i_number != 15'd0) : (i_number == 15'd0)))
        else $error("suite_number does not match event kind");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == EV_NAME_DONE) |-> (i_value == 16'd0))
        else $error("name done beat carries a value");

    a_name_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == EV_NAME_BYTE) |-> (i_value[15:8] == 8'd0))
        else $error("name beat wider than a byte");

    // ready only drops while a stalled event is held
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && $past(i_out_valid && !i_out_ready)))
        else $error("input stalled without a held event");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event shown after reset");

endmodule

bind tls_hello_field_extractor thfe_checker u_thfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.event_kind),
    .i_value     (o_out.event_value),
    .i_number    (o_out.suite_number)
);

`default_nettype wire
